// File: rtl/core/wsfe_pkg.sv
// Shared types, constants and header helpers for the WebSocket frame encoder.
package wsfe_pkg;

    localparam int DEFAULT_LENGTH_BITS = 32;

    // Item kinds on the request channel.
    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_PAYLOAD = 1'b1
    } cmd_t;

    localparam logic [7:0]  FIN_BIT      = 8'h80;
    localparam logic [7:0]  MASK_BIT     = 8'h80;
    localparam logic [6:0]  LEN_CODE_16  = 7'd126;
    localparam logic [6:0]  LEN_CODE_64  = 7'd127;
    localparam logic [31:0] SHORT_LIMIT  = 32'd126;
    localparam logic [31:0] MEDIUM_LIMIT = 32'd65536;

    // Index of the final header byte for each length form.
    localparam logic [3:0] SHORT_LAST  = 4'd5;
    localparam logic [3:0] MEDIUM_LAST = 4'd7;
    localparam logic [3:0] LONG_LAST   = 4'd13;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef struct packed {
        cmd_t        command;
        logic [3:0]  opcode;
        logic [31:0] frame_length;
        logic [31:0] masking_key;
        logic [7:0]  payload_byte;
    } wsfe_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       frame_done;
    } wsfe_res_t;

    // Key byte 0 sits in the most significant bits.
    function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] phase);
        logic [7:0] b;
        begin
            unique case (phase)
                2'd0:    b = key[31:24];
                2'd1:    b = key[23:16];
                2'd2:    b = key[15:8];
                default: b = key[7:0];
            endcase
            return b;
        end
    endfunction

    function automatic logic [3:0] header_last(input logic [31:0] len);
        logic [3:0] last;
        begin
            if (len < SHORT_LIMIT) begin
                last = SHORT_LAST;
            end
            else if (len < MEDIUM_LIMIT) begin
                last = MEDIUM_LAST;
            end
            else begin
                last = LONG_LAST;
            end
            return last;
        end
    endfunction

    // Header byte at position idx (1 and up); byte 0 is built from the opcode.
    function automatic logic [7:0] header_byte(input logic [3:0]  idx,
                                               input logic [3:0]  last,
                                               input logic [31:0] len,
                                               input logic [31:0] key);
        logic [3:0] key_start;
        logic [1:0] len_sel;
        logic [7:0] b;
        begin
            key_start = last - KEY_BYTES + 4'd1;
            len_sel   = 2'(key_start - 4'd1 - idx);
            if (idx == 4'd1) begin
                if (last == SHORT_LAST) begin
                    b = MASK_BIT | {1'b0, len[6:0]};
                end
                else if (last == MEDIUM_LAST) begin
                    b = MASK_BIT | {1'b0, LEN_CODE_16};
                end
                else begin
                    b = MASK_BIT | {1'b0, LEN_CODE_64};
                end
            end
            else if (idx >= key_start) begin
                b = key_byte(key, 2'(idx - key_start));
            end
            else if (idx < key_start - KEY_BYTES) begin
                // Upper half of the 64-bit length is always zero.
                b = 8'h00;
            end
            else begin
                unique case (len_sel)
                    2'd0:    b = len[7:0];
                    2'd1:    b = len[15:8];
                    2'd2:    b = len[23:16];
                    default: b = len[31:24];
                endcase
            end
            return b;
        end
    endfunction

endpackage

// File: rtl/core/wsfe_req_if.sv
// Request channel interface carrying start and payload items.
interface wsfe_req_if
    import wsfe_pkg::*;
();
    logic      valid;
    logic      ready;
    wsfe_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/wsfe_res_if.sv
// Result channel interface carrying frame bytes on the wire.
interface wsfe_res_if
    import wsfe_pkg::*;
();
    logic      valid;
    logic      ready;
    wsfe_res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/websocket_frame_encoder.sv
// Masked client WebSocket frame encoder: turns start and payload requests into frame bytes.
//
// A start request produces the frame header one byte per cycle while the output is free:
// 6 bytes for a payload shorter than 126, 8 bytes below 65536 and 14 bytes otherwise, and the
// request channel holds ready low while the header sequencer walks its byte index.
// Each payload request produces one masked byte and a new payload request is taken every cycle
// the downstream side accepts; the single output register lets the next request enter in the
// same cycle that the held byte is taken. Payload requests arriving outside a frame are accepted
// and dropped, and a start inside an unfinished frame abandons it. LENGTH_BITS limits how many
// low bits of frame_length are used.
module websocket_frame_encoder
    import wsfe_pkg::*;
#(
    parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    wsfe_req_if.sink   req,
    wsfe_res_if.source res
);

    // The payload counter never needs more than 32 bits since frame_length is 32 bits wide.
    localparam int CNT_W = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
    localparam logic [31:0] LEN_MASK = (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF
                                       : 32'((64'd1 << LENGTH_BITS) - 64'd1);

    // Frame state, updated as requests are accepted.
    logic             in_frame_reg;
    logic [CNT_W-1:0] bytes_left_reg;
    logic [31:0]      key_store_reg;
    logic [1:0]       key_phase_reg;

    // Header sequencer.
    logic        hdr_busy_reg;
    logic [3:0]  hdr_idx_reg;
    logic [3:0]  hdr_last_reg;
    logic [31:0] hdr_len_reg;

    // Output register.
    logic      out_valid_reg;
    wsfe_res_t out_data_reg;

    logic        out_free;
    logic        accept;
    logic [31:0] len_masked;

    assign out_free   = !out_valid_reg || res.ready;
    assign req.ready  = !hdr_busy_reg && out_free;
    assign accept     = req.valid && req.ready;
    assign len_masked = req.data.frame_length & LEN_MASK;

    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= '0;
            key_store_reg  <= '0;
            key_phase_reg  <= '0;
            hdr_busy_reg   <= 1'b0;
            hdr_idx_reg    <= '0;
            hdr_last_reg   <= '0;
            hdr_len_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else if (accept) begin
            if (req.data.command == CMD_START) begin
                // First header byte goes out at once; the rest follow from the sequencer.
                out_valid_reg             <= 1'b1;
                out_data_reg.out_byte     <= FIN_BIT | {4'd0, req.data.opcode};
                out_data_reg.last_of_run  <= 1'b0;
                out_data_reg.frame_done   <= 1'b0;
                hdr_busy_reg              <= 1'b1;
                hdr_idx_reg               <= 4'd1;
                hdr_last_reg              <= header_last(len_masked);
                hdr_len_reg               <= len_masked;
                key_store_reg             <= req.data.masking_key;
                key_phase_reg             <= '0;
                bytes_left_reg            <= CNT_W'(len_masked);
                in_frame_reg              <= (len_masked != 32'd0);
            end
            else if (in_frame_reg) begin
                out_valid_reg            <= 1'b1;
                out_data_reg.out_byte    <= req.data.payload_byte
                                            ^ key_byte(key_store_reg, key_phase_reg);
                out_data_reg.last_of_run <= 1'b1;
                out_data_reg.frame_done  <= (bytes_left_reg == CNT_W'(1));
                key_phase_reg            <= key_phase_reg + 2'd1;
                bytes_left_reg           <= bytes_left_reg - CNT_W'(1);
                if (bytes_left_reg == CNT_W'(1)) begin
                    in_frame_reg <= 1'b0;
                end
            end
            else begin
                // Stray payload byte: nothing to send, and the held byte, if any, was just taken.
                out_valid_reg <= 1'b0;
            end
        end
        else if (hdr_busy_reg && out_free) begin
            out_valid_reg            <= 1'b1;
            out_data_reg.out_byte    <= header_byte(hdr_idx_reg, hdr_last_reg,
                                                    hdr_len_reg, key_store_reg);
            out_data_reg.last_of_run <= (hdr_idx_reg == hdr_last_reg);
            out_data_reg.frame_done  <= (hdr_idx_reg == hdr_last_reg)
                                        && (hdr_len_reg == 32'd0);
            hdr_idx_reg              <= hdr_idx_reg + 4'd1;
            if (hdr_idx_reg == hdr_last_reg) begin
                hdr_busy_reg <= 1'b0;
            end
        end
        else if (res.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule
